@@ rtl/core/kr_pkg.sv @@
// Package for the keyed record table: command and status codes, field widths
// and the fixed-point constants for the average in tenths.
// No dependencies.
`timescale 1ns / 1ps

package kr_pkg;

	localparam int KEY_W   = 63;
	localparam int NAMEL_W = 64;
	localparam int NAMEH_W = 16;
	localparam int SCORE_W = 10;
	localparam int AVG_W   = 14;
	localparam int SUM_W   = 12;
	localparam int NUM_W   = 15;
	localparam int RECIP_W = 16;
	localparam int PROD_W  = NUM_W + RECIP_W;

	// floor(x / 3) == (x * 43691) >> 17 for x below 2**17
	localparam logic [RECIP_W-1:0] RECIP       = 16'd43691;
	localparam int                 RECIP_SHIFT = 17;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_UPDATE = 2'd2,
		FUNC_QUERY  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EXISTS  = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage

@@ rtl/core/kr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/keyed_record_table.sv @@
// Keyed record table: one shared key comparator walks the table once per
// transaction. After accept, S_SCAN walks the table, then S_ACT sets done;
// a query that hits passes S_QOUT first. Start is taken only while idle.
// Reset: a clearing pass marks every entry free; busy stays high during it.
// The receiver cannot stall; done pulses for one cycle.
// Depends on kr_pkg and kr_ram.
`timescale 1ns / 1ps

module keyed_record_table
	import kr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [KEY_W-1:0]   key,
	input  logic [NAMEL_W-1:0] name_low,
	input  logic [NAMEH_W-1:0] name_high,
	input  logic [SCORE_W-1:0] score_a,
	input  logic [SCORE_W-1:0] score_b,
	input  logic [SCORE_W-1:0] score_c,
	output logic               done,
	output logic [1:0]         status,
	output logic [KEY_W-1:0]   found_key,
	output logic [NAMEL_W-1:0] out_name_low,
	output logic [NAMEH_W-1:0] out_name_high,
	output logic [AVG_W-1:0]   average_tenths
);

	localparam int            AW   = $clog2(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
	localparam int            NW   = NAMEL_W + NAMEH_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_QOUT
	} state_t;

	state_t state_q;

	logic [AW-1:0]      scan_idx_q;
	logic               issue_q;
	logic               pend_s1;
	logic [AW-1:0]      idx_s1;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic               free_q;
	logic [AW-1:0]      free_idx_q;
	func_t              func_q;
	logic [KEY_W-1:0]   key_q;
	logic [NAMEL_W-1:0] name_low_q;
	logic [NAMEH_W-1:0] name_high_q;
	logic [NUM_W-1:0]   num_q;
	logic [AVG_W-1:0]   avg_q;

	logic               done_q;
	status_t            status_q;
	logic [KEY_W-1:0]   found_key_q;
	logic [NAMEL_W-1:0] name_low_out_q;
	logic [NAMEH_W-1:0] name_high_out_q;
	logic [AVG_W-1:0]   avg_out_q;

	logic [KEY_W:0]    krd;
	logic [NW-1:0]     nrd;
	logic [AVG_W-1:0]  ard;
	logic              kwe;
	logic [AW-1:0]     kwaddr;
	logic [KEY_W:0]    kwdata;
	logic              nwe;
	logic              awe;
	logic [AW-1:0]     awaddr;

	logic              accept;
	logic [SUM_W-1:0]  sum;
	logic [NUM_W-1:0]  num;
	logic [PROD_W-1:0] prod;
	logic              match;
	logic              empty;
	logic              add_ok;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign sum  = SUM_W'(score_a) + SUM_W'(score_b) + SUM_W'(score_c);
	assign num  = (NUM_W'(sum) << 3) + (NUM_W'(sum) << 1) + NUM_W'(1);
	assign prod = PROD_W'(num_q) * PROD_W'(RECIP);

	assign match  = pend_s1 && krd[KEY_W] && (krd[KEY_W-1:0] == key_q);
	assign empty  = pend_s1 && !krd[KEY_W];
	assign add_ok = (func_q == FUNC_ADD) && !hit_q && free_q;

	always_comb begin
		kwe    = 1'b0;
		kwaddr = free_idx_q;
		kwdata = {1'b1, key_q};
		nwe    = 1'b0;
		awe    = 1'b0;
		awaddr = free_idx_q;
		unique case (state_q)
			S_CLEAR: begin
				kwe    = 1'b1;
				kwaddr = scan_idx_q;
				kwdata = '0;
			end
			S_ACT: begin
				if (add_ok) begin
					kwe = 1'b1;
					nwe = 1'b1;
					awe = 1'b1;
				end else if (func_q == FUNC_DELETE && hit_q) begin
					kwe    = 1'b1;
					kwaddr = hit_idx_q;
					kwdata = {1'b0, key_q};
				end else if (func_q == FUNC_UPDATE && hit_q) begin
					awe    = 1'b1;
					awaddr = hit_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	kr_ram #(.WIDTH(KEY_W + 1), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (kwaddr),
		.wdata (kwdata),
		.raddr (scan_idx_q),
		.rdata (krd)
	);

	kr_ram #(.WIDTH(NW), .DEPTH(TABLE_ENTRIES)) u_name_ram (
		.clk   (clk),
		.we    (nwe),
		.waddr (free_idx_q),
		.wdata ({name_high_q, name_low_q}),
		.raddr (hit_idx_q),
		.rdata (nrd)
	);

	kr_ram #(.WIDTH(AVG_W), .DEPTH(TABLE_ENTRIES)) u_avg_ram (
		.clk   (clk),
		.we    (awe),
		.waddr (awaddr),
		.wdata (avg_q),
		.raddr (hit_idx_q),
		.rdata (ard)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			scan_idx_q <= '0;
			issue_q    <= 1'b0;
			pend_s1    <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (scan_idx_q == LAST) begin
						state_q <= S_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_SCAN;
						scan_idx_q  <= '0;
						issue_q     <= 1'b1;
						pend_s1     <= 1'b0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						func_q      <= func_t'(func);
						key_q       <= key;
						name_low_q  <= name_low;
						name_high_q <= name_high;
						num_q       <= num;
					end
				end
				S_SCAN: begin
					avg_q   <= prod[RECIP_SHIFT +: AVG_W];
					pend_s1 <= issue_q;
					idx_s1  <= scan_idx_q;
					if (issue_q) begin
						if (scan_idx_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + AW'(1);
						end
					end
					if (match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (empty && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
					if (pend_s1 && idx_s1 == LAST) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					found_key_q     <= '0;
					name_low_out_q  <= '0;
					name_high_out_q <= '0;
					avg_out_q       <= '0;
					if (func_q == FUNC_QUERY && hit_q) begin
						state_q <= S_QOUT;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						priority if (func_q == FUNC_ADD && hit_q) begin
							status_q <= ST_EXISTS;
						end else if (func_q == FUNC_ADD && !free_q) begin
							status_q <= ST_FULL;
						end else if (!hit_q && func_q != FUNC_ADD) begin
							status_q <= ST_MISSING;
						end else begin
							status_q <= ST_OK;
						end
					end
				end
				S_QOUT: begin
					state_q         <= S_IDLE;
					done_q          <= 1'b1;
					status_q        <= ST_OK;
					found_key_q     <= key_q;
					name_low_out_q  <= nrd[NAMEL_W-1:0];
					name_high_out_q <= nrd[NW-1:NAMEL_W];
					avg_out_q       <= ard;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign found_key      = found_key_q;
	assign out_name_low   = name_low_out_q;
	assign out_name_high  = name_high_out_q;
	assign average_tenths = avg_out_q;

endmodule
